// ----- design/ddpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ddpc_pkg
// Shared types, widths and tables for the go-to-point drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ddpc_pkg;

  localparam int COORD_BITS  = 11;
  localparam int SPEED_LIMIT = 127;

  // datapath widths
  localparam int DW     = COORD_BITS + 1;      // signed delta
  localparam int SQW    = 2 * COORD_BITS + 2;  // dx^2 + dy^2
  localparam int NW     = SQW + 16;            // radicand, Q.16 scaled
  localparam int RTW    = NW / 2;              // root width
  localparam int REMW   = RTW + 2;             // partial remainder
  localparam int NCELL  = RTW;                 // one root bit per cell
  localparam int NCORD  = 16;                  // cordic steps
  localparam int IDXW   = $clog2(NCELL);
  localparam int XW     = DW + 14 + 3;         // cordic x/y
  localparam int ZW     = 26;                  // angle, Q16 degrees
  localparam int SW     = RTW + 18;            // speed term sum, Q16

  localparam logic signed [ZW-1:0] ANG_90_Q16 = ZW'(5898240);

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_TURN  = 1'b1;

  localparam int CFG_IDXW = 2;
  localparam logic [CFG_IDXW-1:0] REG_DRIVE_DIST_GAIN = 2'd0;
  localparam logic [CFG_IDXW-1:0] REG_DRIVE_ANG_GAIN  = 2'd1;
  localparam logic [CFG_IDXW-1:0] REG_TURN_ANG_GAIN   = 2'd2;

  // one request as it moves down the cell chain
  typedef struct packed {
    logic                   opcode;
    logic [3:0]             slot;
    logic signed [8:0]      heading;
    logic signed [8:0]      tgt_heading;
    logic                   spec;       // bearing known without cordic
    logic signed [8:0]      spec_val;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic [NW-1:0]          rad;        // radicand, consumed two bits a cell
    logic [REMW-1:0]        rem;
    logic [RTW-1:0]         root;
  } ddpc_item_t;

  // arctangent of 2^-i in Q16 degrees
  function automatic logic [ZW-1:0] atan_q16(input logic [IDXW-1:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:    a = ZW'(2949120);
      5'd1:    a = ZW'(1740967);
      5'd2:    a = ZW'(919879);
      5'd3:    a = ZW'(466945);
      5'd4:    a = ZW'(234379);
      5'd5:    a = ZW'(117304);
      5'd6:    a = ZW'(58666);
      5'd7:    a = ZW'(29335);
      5'd8:    a = ZW'(14668);
      5'd9:    a = ZW'(7334);
      5'd10:   a = ZW'(3667);
      5'd11:   a = ZW'(1833);
      5'd12:   a = ZW'(917);
      5'd13:   a = ZW'(458);
      5'd14:   a = ZW'(229);
      5'd15:   a = ZW'(115);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- design/ddpc_cell.sv -----
// ----------------------------------------------------------------------------
// ddpc_cell
// One chain cell: one square-root digit step and, where idx is below NCORD, one cordic vectoring step.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpc_cell
  import ddpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [IDXW-1:0]  idx,
  input  wire logic             in_valid,
  input  wire ddpc_item_t       in_item,
  output logic                  out_valid,
  output ddpc_item_t            out_item
);

  logic       valid_r;
  ddpc_item_t item_r, item_nxt;

  logic [REMW+1:0]      rem_sh;
  logic [REMW+1:0]      trial;
  logic signed [XW-1:0] xs, ys;

  // digit step and rotation step
  always_comb begin
    item_nxt = in_item;
    rem_sh   = {in_item.rem, in_item.rad[NW-1 -: 2]};
    trial    = {2'b00, in_item.root, 2'b01};
    item_nxt.rad = {in_item.rad[NW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      item_nxt.rem  = REMW'(rem_sh - trial);
      item_nxt.root = {in_item.root[RTW-2:0], 1'b1};
    end else begin
      item_nxt.rem  = REMW'(rem_sh);
      item_nxt.root = {in_item.root[RTW-2:0], 1'b0};
    end
    xs = in_item.x >>> idx;
    ys = in_item.y >>> idx;
    if (idx < IDXW'(NCORD)) begin
      if (!in_item.y[XW-1]) begin
        item_nxt.x = in_item.x + ys;
        item_nxt.y = in_item.y - xs;
        item_nxt.z = in_item.z + signed'(atan_q16(idx));
      end else begin
        item_nxt.x = in_item.x - ys;
        item_nxt.y = in_item.y + xs;
        item_nxt.z = in_item.z - signed'(atan_q16(idx));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// ----- design/ddpc_post.sv -----
// ----------------------------------------------------------------------------
// ddpc_post
// Heading error wrap and fold, gain products, sum, truncation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpc_post
  import ddpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [15:0]  gain_dist,
  input  wire logic [15:0]  gain_drive_ang,
  input  wire logic [15:0]  gain_turn_ang,
  input  wire logic         in_valid,
  input  wire ddpc_item_t   in_item,
  output logic              out_valid,
  output logic [3:0]        out_slot,
  output logic [7:0]        out_left,
  output logic [7:0]        out_right
);

  // stage 1: error
  logic                    v1_r;
  logic [3:0]              slot1_r;
  logic                    op1_r, rev1_r;
  logic signed [7:0]       err1_r, err1_nxt;
  logic                    rev1_nxt;
  logic [RTW-1:0]          dist1_r;

  logic signed [ZW-1:0]    zneg;
  logic signed [9:0]       bear;
  logic signed [10:0]      e0, e1;

  always_comb begin
    zneg = -in_item.z;
    if (in_item.spec) begin
      bear = 10'(in_item.spec_val);
    end else if (in_item.z[ZW-1]) begin
      bear = -10'(zneg >>> 16);
    end else begin
      bear = 10'(in_item.z >>> 16);
    end
    if (in_item.opcode == OP_TURN) begin
      e0 = 11'(in_item.tgt_heading) - 11'(in_item.heading);
    end else begin
      e0 = 11'(bear) - 11'(in_item.heading);
    end
    if (e0 > 11'sd180) begin
      e1 = e0 - 11'sd360;
    end else if (e0 < -11'sd180) begin
      e1 = e0 + 11'sd360;
    end else begin
      e1 = e0;
    end
    rev1_nxt = 1'b1;
    if (e1 < -11'sd90) begin
      err1_nxt = 8'(e1 + 11'sd180);
    end else if (e1 > 11'sd90) begin
      err1_nxt = 8'(e1 - 11'sd180);
    end else begin
      err1_nxt = 8'(e1);
      rev1_nxt = 1'b0;
    end
  end

  // stage 2: products
  logic                    v2_r;
  logic [3:0]              slot2_r;
  logic                    rev2_r, op2_r;
  logic [RTW+15:0]         dprod2_r;
  logic signed [24:0]      aprod2_r;
  logic [15:0]             ang_gain;

  assign ang_gain = (op1_r == OP_TURN) ? gain_turn_ang : gain_drive_ang;

  // stage 3: sum, truncate, saturate
  logic signed [SW-1:0]    dterm, aterm, sl, sr;
  logic signed [SW-1:0]    ql, qr;
  logic [7:0]              left_nxt, right_nxt;

  function automatic logic signed [SW-1:0] trunc16(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] nv;
    nv = -v;
    return v[SW-1] ? -(nv >>> 16) : (v >>> 16);
  endfunction

  function automatic logic [7:0] sat(input logic signed [SW-1:0] v);
    logic [7:0] r;
    if (v > SW'(SPEED_LIMIT)) begin
      r = 8'(SPEED_LIMIT);
    end else if (v < -SW'(SPEED_LIMIT)) begin
      r = 8'(-SPEED_LIMIT);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  always_comb begin
    if (op2_r == OP_TURN) begin
      dterm = '0;
    end else if (rev2_r) begin
      dterm = -SW'(dprod2_r);
    end else begin
      dterm = SW'(dprod2_r);
    end
    aterm     = SW'(aprod2_r) <<< 8;
    sl        = dterm + aterm;
    sr        = dterm - aterm;
    ql        = trunc16(sl);
    qr        = trunc16(sr);
    left_nxt  = sat(ql);
    right_nxt = sat(qr);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      out_valid <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      slot1_r   <= in_item.slot;
      op1_r     <= in_item.opcode;
      rev1_r    <= rev1_nxt;
      err1_r    <= err1_nxt;
      dist1_r   <= in_item.root;
      slot2_r   <= slot1_r;
      op2_r     <= op1_r;
      rev2_r    <= rev1_r;
      dprod2_r  <= gain_dist * dist1_r;
      aprod2_r  <= signed'({1'b0, ang_gain}) * err1_r;
      out_slot  <= slot2_r;
      out_left  <= left_nxt;
      out_right <= right_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/diff_drive_point_controller_unit.sv -----
// ----------------------------------------------------------------------------
// diff_drive_point_controller_unit
// Differential-drive go-to-point / turn-in-place wheel speed controller.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | opcode, slot, robot pose, target point and heading
//  out_    | master    | slot, left speed, right speed
//  cfg_    | write     | three Q8.8 gains
//
//  One request per cycle while no result is held; NCELL+4 register stages
//  (front stage, 20 sqrt/cordic cells, error, product and output stages).
//  Reset (synchronous, rst_n low) clears valid bits and loads default gains.
//  A held result stalls the whole chain, empty slots included.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_point_controller_unit
  import ddpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // opcode[0] slot[4:1] robot_x[15:5] robot_y[26:16] robot_heading[35:27]
  // target_x[46:36] target_y[57:47] target_heading[66:58]
  input  wire logic [71:0]         in_tdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // slot_out[3:0] left_speed[11:4] right_speed[19:12]
  output logic [23:0]              out_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire logic                cfg_we,
  input  wire logic [CFG_IDXW-1:0] cfg_index,
  input  wire logic [15:0]         cfg_wdata
);

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // gain registers
  logic [15:0] gd_r, ga_r, gt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r <= 16'd51;
      ga_r <= 16'd228;
      gt_r <= 16'd171;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_DIST_GAIN: gd_r <= cfg_wdata;
        REG_DRIVE_ANG_GAIN:  ga_r <= cfg_wdata;
        REG_TURN_ANG_GAIN:   gt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front stage: deltas, squares, special bearings, pre-rotation
  logic signed [DW-1:0]  dx, dy;
  logic [SQW-1:0]        sq;
  logic signed [XW-1:0]  x0, y0;
  ddpc_item_t            f_nxt, f_r;
  logic                  fv_r;

  always_comb begin
    dx = signed'(DW'(in_tdata[46:36])) - signed'(DW'(in_tdata[15:5]));
    dy = signed'(DW'(in_tdata[57:47])) - signed'(DW'(in_tdata[26:16]));
    sq = SQW'(dx * dx) + SQW'(dy * dy);
    x0 = XW'(dx) <<< 14;
    y0 = XW'(dy) <<< 14;
    f_nxt             = '0;
    f_nxt.opcode      = in_tdata[0];
    f_nxt.slot        = in_tdata[4:1];
    f_nxt.heading     = in_tdata[35:27];
    f_nxt.tgt_heading = in_tdata[66:58];
    f_nxt.rad         = {sq, 16'd0};
    f_nxt.x           = x0;
    f_nxt.y           = y0;
    f_nxt.spec        = 1'b1;
    if (dx == '0 && dy == '0) begin
      f_nxt.spec_val = 9'sd90;
    end else if (dy == '0) begin
      f_nxt.spec_val = dx[DW-1] ? 9'sd180 : 9'sd0;
    end else if (dx == '0) begin
      f_nxt.spec_val = dy[DW-1] ? -9'sd90 : 9'sd90;
    end else if (dx == dy) begin
      f_nxt.spec_val = dx[DW-1] ? -9'sd135 : 9'sd45;
    end else if (dx == -dy) begin
      f_nxt.spec_val = dx[DW-1] ? 9'sd135 : -9'sd45;
    end else begin
      f_nxt.spec = 1'b0;
    end
    if (dx[DW-1]) begin
      if (!dy[DW-1]) begin
        f_nxt.x = y0;
        f_nxt.y = -x0;
        f_nxt.z = ANG_90_Q16;
      end else begin
        f_nxt.x = -y0;
        f_nxt.y = x0;
        f_nxt.z = -ANG_90_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  // cell chain
  logic       cv [NCELL+1];
  ddpc_item_t ci [NCELL+1];
  assign cv[0] = fv_r;
  assign ci[0] = f_r;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ddpc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .idx       (IDXW'(g)),
      .in_valid  (cv[g]),
      .in_item   (ci[g]),
      .out_valid (cv[g+1]),
      .out_item  (ci[g+1])
    );
  end

  // error, gains and output register
  logic [3:0] o_slot;
  logic [7:0] o_left, o_right;

  ddpc_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .gain_dist      (gd_r),
    .gain_drive_ang (ga_r),
    .gain_turn_ang  (gt_r),
    .in_valid       (cv[NCELL]),
    .in_item        (ci[NCELL]),
    .out_valid      (out_tvalid),
    .out_slot       (o_slot),
    .out_left       (o_left),
    .out_right      (o_right)
  );

  assign out_tdata = {4'd0, o_right, o_left, o_slot};

endmodule

`default_nettype wire
